>>> design/sgva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgva_pkg: shared types and constants for the signed vector angle block
// Fixed datapath widths after prescaling, CORDIC arctangent table and the
// sideband records that travel with each beat through the pipeline.
// ----------------------------------------------------------------------------
package sgva_pkg;

	// datapath widths after prescaling (components within +-2^15)
	localparam int PS_W    = 17;	// prescaled component, signed
	localparam int PROD_W  = 34;	// component product, signed
	localparam int LEN_W   = 32;	// squared length, unsigned
	localparam int DOT_W   = 33;	// dot product, signed
	localparam int CROSS_W = 33;	// cross product component, signed
	localparam int AXP_W   = 50;	// cross component times axis, signed
	localparam int AXS_W   = 52;	// axis test sum, signed
	localparam int LL_W    = 64;	// product of squared lengths
	localparam int DEN_W   = 32;	// root of that product
	localparam int Q_W     = 31;	// cosine magnitude, Q30
	localparam int NUM_W   = 63;	// divider residual
	localparam int SS_W    = 62;	// 2^60 - c^2
	localparam int CW      = 34;	// CORDIC x, y, z
	localparam int CORDIC_STEPS = 30;
	localparam int ANGLE_W = 16;

	localparam logic [Q_W-1:0]         ONE_Q30     = 31'h4000_0000;
	localparam logic [SS_W-1:0]        ONE_SQ      = 62'h1000_0000_0000_0000;
	localparam logic signed [CW-1:0]   HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CW-1:0]   PI_Q30      = 34'sd3373259426;

	// atan(2^-i) * 2^30, truncated
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	// flags that ride along with every beat
	typedef struct packed {
		logic degenerate;
		logic negate;
	} side_t;

	// carried through the length root
	typedef struct packed {
		logic             dt_neg;
		logic [DEN_W-1:0] dt_mag;
		side_t            side;
	} len_tag_t;

	// carried through the sine root
	typedef struct packed {
		logic           c_neg;
		logic [Q_W-1:0] c_mag;
		side_t          side;
	} sin_tag_t;

endpackage

>>> design/sgva_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgva_isqrt: pipelined integer square root
// Floor root of an unsigned operand, one result bit per stage, with a tag
// that travels alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module sgva_isqrt #(
	parameter int OPND_W = 64,
	parameter int TAG_W  = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [OPND_W-1:0]   in_opnd,
	input  logic [TAG_W-1:0]    in_tag,
	output logic                out_valid,
	output logic [OPND_W/2-1:0] out_root,
	output logic [TAG_W-1:0]    out_tag
);

	localparam int STEPS = OPND_W / 2;

	logic [OPND_W-1:0] rem_s [STEPS];
	logic [OPND_W-1:0] res_s [STEPS];
	logic [TAG_W-1:0]  tag_s [STEPS];
	logic              vld_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [OPND_W-1:0] BIT = OPND_W'(1) << (OPND_W - 2 - 2 * k);
		logic [OPND_W-1:0] rem_in;
		logic [OPND_W-1:0] res_in;
		logic [TAG_W-1:0]  tag_in;
		logic              vld_in;
		logic [OPND_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = in_opnd;
			assign res_in = '0;
			assign tag_in = in_tag;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign tag_in = tag_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		// one trial subtract per stage
		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_in;
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_root  = res_s[STEPS-1][OPND_W/2-1:0];
	assign out_tag   = tag_s[STEPS-1];

endmodule

>>> design/sgva_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgva_cordic: pipelined CORDIC vectoring
// Drives y toward zero over a fixed number of stages and accumulates the
// rotation angle in Q30. Shifts are arithmetic (floor).
// ----------------------------------------------------------------------------
module sgva_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [sgva_pkg::CW-1:0]  in_x,
	input  logic signed [sgva_pkg::CW-1:0]  in_y,
	input  logic signed [sgva_pkg::CW-1:0]  in_z,
	input  sgva_pkg::side_t                 in_side,
	output logic                            out_valid,
	output logic signed [sgva_pkg::CW-1:0]  out_z,
	output sgva_pkg::side_t                 out_side
);

	import sgva_pkg::*;

	logic signed [CW-1:0] x_s [CORDIC_STEPS];
	logic signed [CW-1:0] y_s [CORDIC_STEPS];
	logic signed [CW-1:0] z_s [CORDIC_STEPS];
	side_t                side_s [CORDIC_STEPS];
	logic                 vld_s [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam logic signed [CW-1:0] ATAN_K = $signed(CW'(ATAN_TAB[k]));
		logic signed [CW-1:0] x_in;
		logic signed [CW-1:0] y_in;
		logic signed [CW-1:0] z_in;
		side_t                side_in;
		logic                 vld_in;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;

		if (k == 0) begin : g_first
			assign x_in    = in_x;
			assign y_in    = in_y;
			assign z_in    = in_z;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign x_in    = x_s[k-1];
			assign y_in    = y_s[k-1];
			assign z_in    = z_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		assign xs = x_in >>> k;
		assign ys = y_in >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				if (!y_in[CW-1]) begin
					x_s[k] <= x_in + ys;
					y_s[k] <= y_in - xs;
					z_s[k] <= z_in + ATAN_K;
				end else begin
					x_s[k] <= x_in - ys;
					y_s[k] <= y_in + xs;
					z_s[k] <= z_in - ATAN_K;
				end
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_z     = z_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];

endmodule

>>> design/signed_vector_angle.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle; every stage is a register, the roots and the
// divider resolve one bit per stage and the CORDIC one rotation per stage.
// A stall on m_axis_tready freezes the whole pipeline and drops s_axis_tready.
// Reset clears the valid bits of every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// signed_vector_angle: angle between two 3D vectors
// Prescale, dot/cross products, length root, cosine divide, sine root,
// CORDIC arctangent, then rounding, axis sign and saturation.
// ----------------------------------------------------------------------------
module signed_vector_angle #(
	parameter int COMPONENT_BITS  = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z,
	// ref_axis_x, ref_axis_y, ref_axis_z
	input  logic [((9*COMPONENT_BITS+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                       s_axis_tuser,	// use_ref_axis
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	output logic [sgva_pkg::ANGLE_W-1:0]               m_axis_tdata,	// angle_rad
	output logic                                       m_axis_tuser	// degenerate
);

	import sgva_pkg::*;

	localparam int CB     = COMPONENT_BITS;
	localparam int MAGW   = (CB > 16) ? CB : 17;
	localparam int SMAX   = (CB > 16) ? CB - 16 : 0;
	localparam int SW     = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
	localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
	localparam logic [MAGW-1:0] PS_LIM  = MAGW'(32768);
	localparam logic [32:0]     POS_LIM = 33'((1 << (ANGLE_W - 1)) - 1);
	localparam logic [32:0]     NEG_LIM = 33'(1 << (ANGLE_W - 1));

	logic en;

	// whole pipeline advances unless the output beat is stuck
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: magnitudes and prescale shifts ----------------
	logic signed [CB-1:0] comp_w [9];
	logic [CB-1:0]        magc_w [9];
	logic [MAGW-1:0]      mag_w  [9];
	logic [MAGW-1:0]      vmax_w [3];
	logic [SW-1:0]        shift_w [3];
	logic                 deg_w;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			comp_w[k] = $signed(s_axis_tdata[k*CB +: CB]);
			magc_w[k] = comp_w[k][CB-1] ? CB'(-comp_w[k]) : CB'(comp_w[k]);
			mag_w[k]  = MAGW'(magc_w[k]);
		end
		for (int v = 0; v < 3; v++) begin
			vmax_w[v] = mag_w[3*v];
			if (mag_w[3*v+1] > vmax_w[v]) vmax_w[v] = mag_w[3*v+1];
			if (mag_w[3*v+2] > vmax_w[v]) vmax_w[v] = mag_w[3*v+2];
			// least shift that brings the largest magnitude to at most 2^15
			shift_w[v] = SW'(SMAX);
			for (int t = SMAX; t >= 0; t--) begin
				if ((vmax_w[v] >> t) <= PS_LIM) shift_w[v] = SW'(t);
			end
		end
		deg_w = (vmax_w[0] == '0) || (vmax_w[1] == '0);
	end

	logic [MAGW-1:0] mag_s1 [9];
	logic            neg_s1 [9];
	logic [SW-1:0]   shift_s1 [3];
	logic            use_s1, deg_s1, vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				mag_s1[k] <= mag_w[k];
				neg_s1[k] <= comp_w[k][CB-1];
			end
			for (int v = 0; v < 3; v++) shift_s1[v] <= shift_w[v];
			use_s1 <= s_axis_tuser;
			deg_s1 <= deg_w;
		end
	end

	// ---------------- stage 2: prescaled components ----------------
	logic [MAGW-1:0]        shm_w [9];
	logic signed [PS_W-1:0] pv_w  [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			shm_w[k] = mag_s1[k] >> shift_s1[k/3];
			pv_w[k]  = neg_s1[k] ? -$signed({1'b0, shm_w[k][15:0]})
			                     : $signed({1'b0, shm_w[k][15:0]});
		end
	end

	logic signed [PS_W-1:0] p_s2 [9];
	logic                   use_s2, deg_s2, vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) p_s2[k] <= pv_w[k];
			use_s2 <= use_s1;
			deg_s2 <= deg_s1;
		end
	end

	// ---------------- stage 3: component products ----------------
	logic signed [PROD_W-1:0] ex_w [9];

	always_comb begin
		for (int k = 0; k < 9; k++) ex_w[k] = PROD_W'(p_s2[k]);
	end

	logic signed [PROD_W-1:0] aa_s3 [3];
	logic signed [PROD_W-1:0] bb_s3 [3];
	logic signed [PROD_W-1:0] ab_s3 [3];
	logic signed [PROD_W-1:0] xp_s3 [6];
	logic signed [PS_W-1:0]   r_s3  [3];
	logic                     use_s3, deg_s3, vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				aa_s3[k] <= ex_w[k] * ex_w[k];
				bb_s3[k] <= ex_w[3+k] * ex_w[3+k];
				ab_s3[k] <= ex_w[k] * ex_w[3+k];
				r_s3[k]  <= p_s2[6+k];
			end
			// cross product terms: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
			xp_s3[0] <= ex_w[1] * ex_w[5];
			xp_s3[1] <= ex_w[2] * ex_w[4];
			xp_s3[2] <= ex_w[2] * ex_w[3];
			xp_s3[3] <= ex_w[0] * ex_w[5];
			xp_s3[4] <= ex_w[0] * ex_w[4];
			xp_s3[5] <= ex_w[1] * ex_w[3];
			use_s3 <= use_s2;
			deg_s3 <= deg_s2;
		end
	end

	// ---------------- stage 4: lengths, dot and cross ----------------
	logic [LEN_W-1:0]          la_s4, lb_s4;
	logic signed [DOT_W-1:0]   dt_s4;
	logic signed [CROSS_W-1:0] cr_s4 [3];
	logic signed [PS_W-1:0]    r_s4  [3];
	logic                      use_s4, deg_s4, vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			la_s4 <= LEN_W'(aa_s3[0] + aa_s3[1] + aa_s3[2]);
			lb_s4 <= LEN_W'(bb_s3[0] + bb_s3[1] + bb_s3[2]);
			dt_s4 <= DOT_W'(ab_s3[0] + ab_s3[1] + ab_s3[2]);
			for (int k = 0; k < 3; k++) begin
				cr_s4[k] <= CROSS_W'(xp_s3[2*k] - xp_s3[2*k+1]);
				r_s4[k]  <= r_s3[k];
			end
			use_s4 <= use_s3;
			deg_s4 <= deg_s3;
		end
	end

	// ---------------- stage 5: length product, axis terms ----------------
	logic [LL_W-1:0]         ll_s5;
	logic signed [AXP_W-1:0] crr_s5 [3];
	logic signed [DOT_W-1:0] dt_s5;
	logic                    use_s5, deg_s5, vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s5 <= LL_W'(la_s4) * LL_W'(lb_s4);
			for (int k = 0; k < 3; k++) crr_s5[k] <= AXP_W'(cr_s4[k]) * AXP_W'(r_s4[k]);
			dt_s5  <= dt_s4;
			use_s5 <= use_s4;
			deg_s5 <= deg_s4;
		end
	end

	// ---------------- stage 6: axis sign test ----------------
	logic signed [AXS_W-1:0] axs_w;
	len_tag_t                tag6_w;

	always_comb begin
		axs_w = AXS_W'(crr_s5[0]) + AXS_W'(crr_s5[1]) + AXS_W'(crr_s5[2]);
		tag6_w.dt_neg          = dt_s5[DOT_W-1];
		tag6_w.dt_mag          = dt_s5[DOT_W-1] ? DEN_W'(-dt_s5) : DEN_W'(dt_s5);
		tag6_w.side.degenerate = deg_s5;
		tag6_w.side.negate     = use_s5 && axs_w[AXS_W-1];
	end

	logic [LL_W-1:0] ll_s6;
	len_tag_t        tag_s6;
	logic            vld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s6  <= ll_s5;
			tag_s6 <= tag6_w;
		end
	end

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---------------- length root ----------------
	logic                       root_vld;
	logic [DEN_W-1:0]           root_w;
	logic [$bits(len_tag_t)-1:0] root_tag_raw;
	len_tag_t                   root_tag;

	sgva_isqrt #(
		.OPND_W(LL_W),
		.TAG_W ($bits(len_tag_t))
	) u_len_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s6),
		.in_opnd  (ll_s6),
		.in_tag   (tag_s6),
		.out_valid(root_vld),
		.out_root (root_w),
		.out_tag  (root_tag_raw)
	);

	assign root_tag = len_tag_t'(root_tag_raw);

	// ---------------- cosine divide, one quotient bit per stage ----------------
	logic [NUM_W-1:0] dv_rem_s [Q_W];
	logic [Q_W-1:0]   dv_quo_s [Q_W];
	logic [DEN_W-1:0] dv_den_s [Q_W];
	len_tag_t         dv_tag_s [Q_W];
	logic             dv_vld_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int BIT = Q_W - 1 - j;
		logic [NUM_W-1:0] rem_in;
		logic [Q_W-1:0]   quo_in;
		logic [DEN_W-1:0] den_in;
		len_tag_t         tag_in;
		logic             vld_in;
		logic [NUM_W-1:0] sub_w;

		if (j == 0) begin : g_first
			assign rem_in = NUM_W'(root_tag.dt_mag) << (Q_W - 1);
			assign quo_in = '0;
			assign den_in = (root_w == '0) ? DEN_W'(1) : root_w;
			assign tag_in = root_tag;
			assign vld_in = root_vld;
		end else begin : g_next
			assign rem_in = dv_rem_s[j-1];
			assign quo_in = dv_quo_s[j-1];
			assign den_in = dv_den_s[j-1];
			assign tag_in = dv_tag_s[j-1];
			assign vld_in = dv_vld_s[j-1];
		end

		assign sub_w = NUM_W'(den_in) << BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[j] <= den_in;
				dv_tag_s[j] <= tag_in;
				if (rem_in >= sub_w) begin
					dv_rem_s[j] <= rem_in - sub_w;
					dv_quo_s[j] <= quo_in | (Q_W'(1) << BIT);
				end else begin
					dv_rem_s[j] <= rem_in;
					dv_quo_s[j] <= quo_in;
				end
			end
		end
	end

	// ---------------- cosine clamp, square, complement ----------------
	logic [Q_W-1:0]  qf_w;
	logic [Q_W-1:0]  cm_c1, cm_c2, cm_c3;
	logic            cn_c1, cn_c2, cn_c3;
	side_t           sd_c1, sd_c2, sd_c3;
	logic            vld_c1, vld_c2, vld_c3;
	logic [SS_W-1:0] sq_c2;
	logic [SS_W-1:0] ss_c3;
	sin_tag_t        stag_w;

	assign qf_w = dv_quo_s[Q_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			cm_c1 <= (qf_w > ONE_Q30) ? ONE_Q30 : qf_w;
			cn_c1 <= dv_tag_s[Q_W-1].dt_neg;
			sd_c1 <= dv_tag_s[Q_W-1].side;
			sq_c2 <= SS_W'(cm_c1) * SS_W'(cm_c1);
			cm_c2 <= cm_c1;
			cn_c2 <= cn_c1;
			sd_c2 <= sd_c1;
			ss_c3 <= ONE_SQ - sq_c2;
			cm_c3 <= cm_c2;
			cn_c3 <= cn_c2;
			sd_c3 <= sd_c2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
		end else if (en) begin
			vld_c1 <= dv_vld_s[Q_W-1];
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
		end
	end

	assign stag_w.c_neg = cn_c3;
	assign stag_w.c_mag = cm_c3;
	assign stag_w.side  = sd_c3;

	// ---------------- sine root ----------------
	logic                        sin_vld;
	logic [SS_W/2-1:0]           sin_w;
	logic [$bits(sin_tag_t)-1:0] sin_tag_raw;
	sin_tag_t                    sin_tag;

	sgva_isqrt #(
		.OPND_W(SS_W),
		.TAG_W ($bits(sin_tag_t))
	) u_sin_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_c3),
		.in_opnd  (ss_c3),
		.in_tag   (stag_w),
		.out_valid(sin_vld),
		.out_root (sin_w),
		.out_tag  (sin_tag_raw)
	);

	assign sin_tag = sin_tag_t'(sin_tag_raw);

	// ---------------- CORDIC start, quarter turn for negative cosine ----------------
	logic                 rot_w;
	logic signed [CW-1:0] x_k0, y_k0, z_k0;
	side_t                sd_k0;
	logic                 vld_k0;

	assign rot_w = sin_tag.c_neg && (sin_tag.c_mag != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			x_k0  <= rot_w ? $signed(CW'(sin_w)) : $signed(CW'(sin_tag.c_mag));
			y_k0  <= rot_w ? $signed(CW'(sin_tag.c_mag)) : $signed(CW'(sin_w));
			z_k0  <= rot_w ? HALF_PI_Q30 : '0;
			sd_k0 <= sin_tag.side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_k0 <= 1'b0;
		end else if (en) begin
			vld_k0 <= sin_vld;
		end
	end

	logic                 cd_vld;
	logic signed [CW-1:0] cd_z;
	side_t                cd_side;

	sgva_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_k0),
		.in_x     (x_k0),
		.in_y     (y_k0),
		.in_z     (z_k0),
		.in_side  (sd_k0),
		.out_valid(cd_vld),
		.out_z    (cd_z),
		.out_side (cd_side)
	);

	// ---------------- clamp, round, sign, saturate ----------------
	logic [31:0]        zc_w;
	logic [32:0]        rnd_w;
	logic [32:0]        amag_w;
	logic [ANGLE_W-1:0] ang_w;

	always_comb begin
		if (cd_z[CW-1]) begin
			zc_w = '0;
		end else if (cd_z > PI_Q30) begin
			zc_w = PI_Q30[31:0];
		end else begin
			zc_w = cd_z[31:0];
		end
		rnd_w  = 33'(zc_w) + (33'(1) << (RND_SH - 1));
		amag_w = rnd_w >> RND_SH;
		if (cd_side.degenerate) begin
			ang_w = '0;
		end else if (cd_side.negate) begin
			ang_w = (amag_w > NEG_LIM) ? NEG_LIM[ANGLE_W-1:0]
			                           : ANGLE_W'(~amag_w[ANGLE_W-1:0] + 1'b1);
		end else begin
			ang_w = (amag_w > POS_LIM) ? POS_LIM[ANGLE_W-1:0] : amag_w[ANGLE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= cd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= ang_w;
			m_axis_tuser <= cd_side.degenerate;
		end
	end

endmodule

>>> design/sgva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgva_checker: port-level assertions for signed_vector_angle
// Watches the stream handshakes and result beats; bound to the top level.
// ----------------------------------------------------------------------------
module sgva_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [sgva_pkg::ANGLE_W-1:0]  m_axis_tdata,
	input logic                          m_axis_tuser
);

	// a degenerate beat always carries a zero angle
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("degenerate beat with nonzero angle");

	// the input side never stalls while the output side is taking beats
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output ready");

	// an empty output register never holds back the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// both input handshake lines and the output valid are driven to known levels out of reset
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
		else $error("unknown level on a handshake line");

endmodule

bind signed_vector_angle sgva_checker u_sgva_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

>>> verif/signed_vector_angle_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_vector_angle_tb: self-checking bench for the vector angle pipeline
// A directed table covers zero vectors, extreme components, opposite and
// perpendicular pairs and the axis sign cases. Random beats follow. Every
// accepted beat is predicted by a bit-exact fixed point angle model and
// checked in order against the output stream. Both sides idle at random,
// and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module signed_vector_angle_tb;

	localparam int N_RANDOM    = 930;
	localparam int HOLD_CYCLES = 400;
	localparam int WDOG_LIMIT  = 4000;
	localparam int DRAIN       = 200;

	typedef struct packed {
		logic signed [15:0] angle;
		logic               degen;
	} angle_res_t;

	typedef struct {
		logic signed [15:0] comp [9];	// a xyz, b xyz, axis xyz
		logic               use_axis;
		bit                 typed;	// expected value given in the row
		angle_res_t         res;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;	// first_x .. first_z, second_x .. second_z, ref_axis_x .. z
	logic         s_axis_tuser;	// use_ref_axis
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [15:0]  m_axis_tdata;	// angle_rad
	logic         m_axis_tuser;	// degenerate

	angle_res_t pending_angles [$];
	stim_row_t  rows [$];
	int         fails;
	int         n_in;
	int         n_out;
	int         n_degen;
	int         n_neg;
	bit         calm;
	bit         hold_req;

	signed_vector_angle i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// expected angle for one beat; components stay within +-2^15, no prescale shift
	function automatic angle_res_t vector_angle(input logic [143:0] d, input logic use_axis);
		longint a [3];
		longint b [3];
		longint r [3];
		longint cr [3];
		longint dt, c, x, y, z, nx, xs, ys, ang;
		longint unsigned la, lb, den, q, sn, mdt;
		angle_res_t res;
		for (int k = 0; k < 3; k++) begin
			a[k] = longint'($signed(d[16*k +: 16]));
			b[k] = longint'($signed(d[16*(k+3) +: 16]));
			r[k] = longint'($signed(d[16*(k+6) +: 16]));
		end
		if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
			res.angle = '0;
			res.degen = 1'b1;
			return res;
		end
		la  = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		lb  = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
		den = int_sqrt(la * lb);	// 64-bit wrap, as in the datapath
		if (den == 0) den = 1;
		dt  = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
		mdt = (dt < 0) ? -dt : dt;
		q   = (mdt << 30) / den;
		if (q > 64'd1073741824) q = 64'd1073741824;
		c   = (dt < 0) ? -longint'(q) : longint'(q);
		sn  = int_sqrt(64'h1000_0000_0000_0000 - longint'(c * c));
		// CORDIC vectoring, quarter turn first for negative cosine
		x = c;
		y = longint'(sn);
		z = 0;
		if (x < 0) begin
			nx = y;
			y  = -x;
			x  = nx;
			z  = longint'(sgva_pkg::HALF_PI_Q30);
		end
		for (int k = 0; k < sgva_pkg::CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(sgva_pkg::ATAN_TAB[k]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(sgva_pkg::ATAN_TAB[k]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(sgva_pkg::PI_Q30)) z = longint'(sgva_pkg::PI_Q30);
		ang = (z + (longint'(1) << 16)) >>> 17;
		if (use_axis) begin
			cr[0] = a[1]*b[2] - a[2]*b[1];
			cr[1] = a[2]*b[0] - a[0]*b[2];
			cr[2] = a[0]*b[1] - a[1]*b[0];
			if (cr[0]*r[0] + cr[1]*r[1] + cr[2]*r[2] < 0) ang = -ang;
		end
		if (ang > 32767) ang = 32767;
		if (ang < -32768) ang = -32768;
		res.angle = ang[15:0];
		res.degen = 1'b0;
		return res;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 9))
			0:       return 16'sd0;
			1:       return -16'sd32768;
			2:       return 16'sd32767;
			3, 4, 5: return 16'($signed($urandom_range(0, 2048)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stim_row_t mk_row(input int ax, ay, az, bx, by, bz, rx, ry, rz,
			input logic use_axis, input bit typed, input int e_ang, input logic e_degen);
		stim_row_t s;
		s.comp = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
			16'(rx), 16'(ry), 16'(rz)};
		s.use_axis  = use_axis;
		s.typed     = typed;
		s.res.angle = 16'(e_ang);
		s.res.degen = e_degen;
		return s;
	endfunction

	// input side: accepted beats get their prediction queued
	always @(posedge clk) begin
		angle_res_t p;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			p = vector_angle(s_axis_tdata, s_axis_tuser);
			pending_angles.push_back(p);
			n_in++;
			if (p.degen) n_degen++;
			if (p.angle[15]) n_neg++;
		end
	end

	// output side: compare against the oldest prediction
	always @(posedge clk) begin
		angle_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_out++;
			if (pending_angles.size() == 0) begin
				$error("unexpected output beat: angle_rad=%0d degenerate=%0b",
					$signed(m_axis_tdata), m_axis_tuser);
				fails++;
			end else begin
				e = pending_angles.pop_front();
				if (m_axis_tdata !== e.angle) begin
					$error("angle_rad: expected %0d, got %0d", e.angle, $signed(m_axis_tdata));
					fails++;
				end
				if (m_axis_tuser !== e.degen) begin
					$error("degenerate: expected %0b, got %0b", e.degen, m_axis_tuser);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat on either side
	always @(posedge clk) begin
		static int idle_cnt = 0;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", WDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// output backpressure, random stalls plus one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
				@(posedge clk);
			end
		end
	end

	task automatic send_beat(input stim_row_t s);
		logic [143:0] d;
		for (int k = 0; k < 9; k++) d[16*k +: 16] = s.comp[k];
		while (!calm && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= s.use_axis;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// typed rows also have the expected value of their row checked against the predictor
		if (s.typed && vector_angle(d, s.use_axis) !== s.res) begin
			$error("table row: expected angle %0d degenerate %0b, predictor disagrees",
				s.res.angle, s.res.degen);
			fails++;
		end
	endtask

	initial begin
		stim_row_t s;
		fails = 0; n_in = 0; n_out = 0; n_degen = 0; n_neg = 0;
		calm = 1'b0; hold_req = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// zero vectors report degenerate with angle 0, axis or not
		rows.push_back(mk_row(0, 0, 0, 256, 0, 0, 0, 0, 256, 1'b0, 1, 0, 1'b1));
		rows.push_back(mk_row(256, 512, 0, 0, 0, 0, -1, -1, -1, 1'b1, 1, 0, 1'b1));
		rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1, 0, 1'b1));
		rows.push_back(mk_row(0, 0, 0, -32768, -32768, -32768, 32767, 0, 0, 1'b0, 1, 0, 1'b1));
		// parallel and opposite
		rows.push_back(mk_row(256, 0, 0, 512, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		rows.push_back(mk_row(256, 0, 0, -256, 0, 0, 0, 0, 256, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(1, 1, 1, 1, 1, 1, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		// extreme components
		rows.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(32767, 32767, 32767, -32768, -32768, -32768,
			32767, 32767, 32767, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(32767, -32768, 0, -32768, 32767, 1, 0, 0, 32767, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768, 1'b1, 0, 0, 1'b0));
		// perpendicular, axis along, against, zero, in-plane, unused
		rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 0, 0, 256, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 0, 0, -256, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 256, 0, 0, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 0, 0, -256, 1'b0, 0, 0, 1'b0));
		// obtuse and acute with negative sign
		rows.push_back(mk_row(256, 10, 0, -200, 100, 0, 0, 0, -1, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(300, 0, 5, 300, -1, 5, 0, 0, 1, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(1, 0, 0, 0, -1, 0, 0, 0, 1, 1'b1, 0, 0, 1'b0));
		rows.push_back(mk_row(-1, 0, 0, 32767, 1, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		foreach (rows[i]) send_beat(rows[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 250 && i < 400);
			if (i == 550) hold_req = 1'b1;
			for (int k = 0; k < 9; k++) s.comp[k] = rand_comp();
			if ($urandom_range(0, 19) == 0)
				for (int k = 0; k < 3; k++) s.comp[k] = 16'sd0;
			if ($urandom_range(0, 19) == 0)
				for (int k = 3; k < 6; k++) s.comp[k] = 16'sd0;
			s.use_axis = $urandom_range(0, 1);
			s.typed    = 0;
			s.res      = '0;
			send_beat(s);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		wait (pending_angles.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d beats in, %0d out: %0d degenerate, %0d negative angles,",
			n_in, n_out, n_degen, n_neg);
		$display("with random stalls on both sides and a %0d-cycle output hold-off.", HOLD_CYCLES);
		if (fails == 0 && pending_angles.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/sgva_pkg.sv
design/sgva_isqrt.sv
design/sgva_cordic.sv
design/signed_vector_angle.sv
design/sgva_checker.sv
verif/signed_vector_angle_tb.sv
